/* design/dns_name_label_encoder_unit_defines.svh */
// Assertion macros used by the label encoder datapath.
`ifndef DNS_NAME_LABEL_ENCODER_UNIT_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dnle_pkg.sv */
// Shared constants and controller/datapath interface types of the label encoder.
package dnle_pkg;

  localparam int MaxLabel = 63;
  localparam int MaxName  = 255;

  localparam int LenW  = 6;   // label length, 0..MaxLabel
  localparam int EncW  = 9;   // encoded name length, 0..MaxName
  localparam int PosW  = 7;   // byte position inside one item's wire bytes
  localparam int LblAw = 6;   // label store address

  localparam logic [7:0] SepChar = 8'h2E;

  // Error flag bits.
  localparam int ErrLabelBit = 0;
  localparam int ErrNameBit  = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // input item accepted this cycle
    logic rd_en;   // read two label bytes for the next pair
    logic emit;    // load the next pair into the output register
  } dnle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_out;    // the item at the input produces at least one result
    logic out_free;   // output register can take a new result this cycle
    logic last_pair;  // the pair at the current position is the item's last
  } dnle_stat_t;

endpackage

/* design/dnle_ctrl.sv */
// Controller state machine of the label encoder.
module dnle_ctrl
  import dnle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dnle_stat_t stat_i,
  output dnle_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd_o.take  = 1'b0;
    cmd_o.rd_en = 1'b0;
    cmd_o.emit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.take = 1'b1;
          if (stat_i.has_out) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_pair) begin
            state_nxt = S_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/dnle_datapath.sv */
// Datapath of the label encoder: label store, counters, pair builder and output register.
`include "dns_name_label_encoder_unit_defines.svh"

module dnle_datapath
  import dnle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_ch,
  input  logic        in_end,
  input  dnle_cmd_t   cmd_i,
  output dnle_stat_t  stat_o,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  output logic [2:0]  out_tuser
);

  logic [7:0]      label_mem [0:(2**LblAw)-1];

  logic [LenW-1:0] lbl_len_r, lbl_len_nxt;
  logic [EncW-1:0] enc_len_r, enc_len_nxt;
  logic [1:0]      err_r, err_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            fl_r;
  logic            end_r;
  logic [LenW-1:0] fl_len_r;
  logic [7:0]      rd_a_r;
  logic [7:0]      rd_b_r;
  logic [7:0]      out_first_r;
  logic [7:0]      out_second_r;
  logic            out_pair_r;
  logic            out_done_r;
  logic [1:0]      out_err_r;

  // Input item decode.
  logic            is_sep;
  logic            store_ch;
  logic            drop_ch;
  logic            boundary;
  logic [LenW-1:0] len_new;
  logic            flush;

  assign is_sep   = (in_ch == SepChar);
  assign store_ch = !is_sep && (lbl_len_r < LenW'(MaxLabel));
  assign drop_ch  = !is_sep && !store_ch;
  assign boundary = is_sep || in_end;
  assign len_new  = lbl_len_r + LenW'(store_ch);
  assign flush    = boundary && (len_new != '0);

  // Pair at the current position: byte pos_r and byte pos_r + 1.
  logic [PosW-1:0] pos_p1;
  logic [PosW-1:0] pos_p2;
  logic [PosW-1:0] fl_len_ext;
  logic [PosW-1:0] n_bytes;
  logic            pair;
  logic            last;
  logic [7:0]      byte_a;
  logic [7:0]      byte_b;

  assign pos_p1     = pos_r + PosW'(1);
  assign pos_p2     = pos_r + PosW'(2);
  assign fl_len_ext = PosW'(fl_len_r);
  assign n_bytes    = (fl_r ? (fl_len_ext + PosW'(1)) : '0) + PosW'(end_r);
  assign pair       = (pos_p1 < n_bytes);
  assign last       = (pos_p2 >= n_bytes);

  // Byte zero is the length byte, then label bytes, then the root zero byte.
  always_comb begin
    if (pos_r == '0) begin
      byte_a = fl_r ? 8'(fl_len_r) : 8'h00;
    end else if (fl_r && (pos_r <= fl_len_ext)) begin
      byte_a = rd_a_r;
    end else begin
      byte_a = 8'h00;
    end
    byte_b = (fl_r && (pos_p1 <= fl_len_ext)) ? rd_b_r : 8'h00;
  end

  // Name length count with saturation and overflow flag.
  logic [EncW:0] enc_sum;
  logic          name_ovf;
  logic [1:0]    err_emit;

  assign enc_sum  = {1'b0, enc_len_r} + (EncW+1)'(pair ? 2 : 1);
  assign name_ovf = (enc_sum > (EncW+1)'(MaxName));
  always_comb begin
    err_emit             = err_r;
    err_emit[ErrNameBit] = err_r[ErrNameBit] | name_ovf;
  end

  // Status to the controller.
  assign stat_o.has_out   = flush || in_end;
  assign stat_o.out_free  = !out_valid_r || out_tready;
  assign stat_o.last_pair = last;

  // Next values of the control registers.
  always_comb begin
    lbl_len_nxt   = lbl_len_r;
    enc_len_nxt   = enc_len_r;
    err_nxt       = err_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (cmd_i.take) begin
      lbl_len_nxt           = boundary ? '0 : len_new;
      err_nxt[ErrLabelBit]  = err_r[ErrLabelBit] | drop_ch;
      pos_nxt               = '0;
    end
    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = pos_p2;
      if (end_r && last) begin
        enc_len_nxt = '0;
        err_nxt     = '0;
      end else begin
        enc_len_nxt = name_ovf ? EncW'(MaxName) : enc_sum[EncW-1:0];
        err_nxt     = err_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbl_len_r   <= '0;
      enc_len_r   <= '0;
      err_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lbl_len_r   <= lbl_len_nxt;
      enc_len_r   <= enc_len_nxt;
      err_r       <= err_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item latches, taken when the item is accepted.
  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      fl_r     <= flush;
      end_r    <= in_end;
      fl_len_r <= len_new;
    end
  end

  // Label store: one write port, two registered read ports.
  logic [PosW-1:0]  rd_base;
  logic [PosW-1:0]  rd_base_m1;
  logic [LblAw-1:0] rd_addr_a;
  logic [LblAw-1:0] rd_addr_b;

  assign rd_base    = cmd_i.emit ? pos_p2 : pos_r;
  assign rd_base_m1 = rd_base - PosW'(1);
  assign rd_addr_a  = rd_base_m1[LblAw-1:0];
  assign rd_addr_b  = rd_base[LblAw-1:0];

  always_ff @(posedge clk) begin
    if (cmd_i.take && store_ch) begin
      label_mem[lbl_len_r[LblAw-1:0]] <= in_ch;
    end
    if (cmd_i.rd_en) begin
      rd_a_r <= label_mem[rd_addr_a];
      rd_b_r <= label_mem[rd_addr_b];
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_first_r  <= byte_a;
      out_second_r <= byte_b;
      out_pair_r   <= pair;
      out_done_r   <= end_r && last;
      out_err_r    <= (end_r && last) ? err_emit : 2'b00;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_second_r, out_first_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = {out_err_r, out_pair_r};

  // A new result never overwrites one that is still waiting.
  `DNLE_ASSERT_NOW(a_emit_free, cmd_i.emit, !out_valid_r || out_tready, "result overwritten")
  // Errors are only reported on the result that closes a name.
  `DNLE_ASSERT_NOW(a_err_on_done, out_tvalid && (out_tuser[2:1] != 2'b00), out_tlast, "error off name end")
  // Closing a name clears its length count and error flags.
  `DNLE_ASSERT_NEXT(a_name_clear, cmd_i.emit && end_r && last, (enc_len_r == '0) && (err_r == '0), "name state not cleared")
  // The label length never passes the label limit.
  `DNLE_ASSERT_NOW(a_lbl_len, 1'b1, lbl_len_r <= LenW'(MaxLabel), "label length out of range")

endmodule

/* design/dns_name_label_encoder_unit.sv */
// Top level of the DNS name label encoder.
//
// Takes a dotted name one character per item (in_tlast marks the final character) and
// gives its DNS wire bytes two per result: each label as a length byte and its characters,
// then the root zero byte, flagged by out_tlast. A character item that does not close a
// label gives no result. An item that closes a label of L characters is accepted, passes
// a fetch state for the first label store read, then gives one result per cycle while the
// output is free, ceil(n/2) results for its n wire bytes (L + 1, plus one with the root
// byte), set by the two-port label store that feeds one byte pair a cycle; the next item
// is taken in the cycle after the last result is loaded, while that result may still wait
// in the output register. Labels longer than 63 characters are cut, and names past 255
// bytes are still sent in full; both are reported in out_tuser on the name's last result.
module dns_name_label_encoder_unit
  import dnle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // name_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] first_byte, [15:8] second_byte
  output logic        out_tlast,  // name_done
  output logic [2:0]  out_tuser   // [0] pair_valid, [2:1] error_code
);

  dnle_cmd_t  cmd;
  dnle_stat_t stat;

  dnle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dnle_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_tdata),
    .in_end     (in_tlast),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
